// ===== sv/ats_pkg.sv =====
// Shared types, constants and saturation helpers for the ASCII token scanner.
// Used by ats_scan_core, ats_result_fifo and ascii_token_scanner; no dependencies.
`default_nettype none

package ats_pkg;

   // Internal counter widths.
   localparam int POSITION_WIDTH = 24;
   localparam int LINE_WIDTH     = 16;

   // Fixed widths of the result fields.
   localparam int KIND_W   = 4;
   localparam int LINE_W   = 16;
   localparam int COLUMN_W = 16;
   localparam int OFFSET_W = 24;
   localparam int LENGTH_W = 16;

   // Result queue geometry.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef logic [POSITION_WIDTH-1:0] pos_type;
   typedef logic [LINE_WIDTH-1:0]     line_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_LPAREN   = 4'd0,
      KIND_RPAREN   = 4'd1,
      KIND_NOT      = 4'd2,
      KIND_AND      = 4'd3,
      KIND_OR       = 4'd4,
      KIND_DASH     = 4'd5,
      KIND_GT       = 4'd6,
      KIND_VARIABLE = 4'd7,
      KIND_ERROR    = 4'd8,
      KIND_END      = 4'd9
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_SKIP
   } mode_type;

   // Character codes the scanner recognizes.
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_BANG    = 8'h21;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_PIPE    = 8'h7C;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_GT      = 8'h3E;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_VTAB    = 8'h0B;
   localparam logic [7:0] CHAR_FF      = 8'h0C;
   localparam logic [7:0] CHAR_CR      = 8'h0D;

   typedef struct packed {
      kind_type              kind;
      logic [LINE_W-1:0]     line;
      logic [COLUMN_W-1:0]   column;
      logic [OFFSET_W-1:0]   offset;
      logic [LENGTH_W-1:0]   length;
      logic                  last;
   } result_type;

   // Up to two results produced by one input beat, first in order first.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic [15:0] sat_pos16(input pos_type v);
      logic [32:0] wide;
      wide = 33'(v);
      if (wide > 33'(17'h0FFFF)) begin
         return '1;
      end
      return wide[15:0];
   endfunction

   function automatic logic [23:0] sat_pos24(input pos_type v);
      logic [32:0] wide;
      wide = 33'(v);
      if (wide > 33'(25'h0FFFFFF)) begin
         return '1;
      end
      return wide[23:0];
   endfunction

   function automatic logic [15:0] sat_line16(input line_type v);
      logic [32:0] wide;
      wide = 33'(v);
      if (wide > 33'(17'h0FFFF)) begin
         return '1;
      end
      return wide[15:0];
   endfunction

   function automatic pos_type pos_inc(input pos_type v);
      if (v == '1) begin
         return v;
      end
      return v + pos_type'(1);
   endfunction

   function automatic line_type line_inc(input line_type v);
      if (v == '1) begin
         return v;
      end
      return v + line_type'(1);
   endfunction

endpackage

`default_nettype wire

// ===== sv/ascii_token_scanner.sv =====
// An accepted byte waits in the input register, then its results enter the result queue.
// Throughput: one byte per cycle while req_stall is low; a byte that yields two results needs two output beats.
// The result port moves one token per cycle while rsp_stall is low, which sets the rate when tokens pile up.
// Reset is synchronous and active high; it clears the scanner state, the input
// register and the result queue. No clearing pass is needed.
`default_nettype none

module ascii_token_scanner (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_char_code,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_token_kind,
   output logic [15:0]      rsp_token_line,
   output logic [15:0]      rsp_token_column,
   output logic [23:0]      rsp_token_offset,
   output logic [15:0]      rsp_ident_length,
   output logic             rsp_last_of_run
);

   logic                in_valid_ff, in_valid_in;
   logic                in_op_ff;
   logic [7:0]          in_char_ff;
   logic                room;
   logic                advance;
   logic                load;
   ats_pkg::push_type   push;
   ats_pkg::result_type head;

   always_comb begin
      advance     = in_valid_ff && room;
      req_stall   = in_valid_ff && !room;
      load        = req_valid && !req_stall;
      in_valid_in = load || (in_valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_op_ff   <= req_op;
         in_char_ff <= req_char_code;
      end
   end

   ats_scan_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .op        (in_op_ff),
      .char_code (in_char_ff),
      .push      (push)
   );

   ats_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (head)
   );

   always_comb begin
      rsp_token_kind   = head.kind;
      rsp_token_line   = head.line;
      rsp_token_column = head.column;
      rsp_token_offset = head.offset;
      rsp_ident_length = head.length;
      rsp_last_of_run  = head.last;
   end

endmodule

`default_nettype wire

// ===== sv/ats_scan_core.sv =====
// Scanner state machine and position counters; turns one byte beat into up to two results.
// Depends on ats_pkg.
`default_nettype none

module ats_scan_core (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          fire,
   input  wire logic          op,
   input  wire logic [7:0]    char_code,
   output ats_pkg::push_type  push
);

   ats_pkg::mode_type mode_ff, mode_in;
   ats_pkg::pos_type  byte_ff, byte_in;
   ats_pkg::line_type line_ff, line_in;
   ats_pkg::pos_type  line_start_ff, line_start_in;
   ats_pkg::pos_type  tok_start_ff, tok_start_in;
   ats_pkg::line_type tok_line_ff, tok_line_in;

   logic              is_letter;
   logic              is_alnum;
   logic              is_space;
   logic              is_blank;
   logic              is_newline;
   logic              is_punct;
   ats_pkg::kind_type punct_kind;
   logic              do_scan;
   logic              do_flush;
   logic              scan_emit;
   logic              other_valid;
   ats_pkg::result_type flush_r;
   ats_pkg::result_type scan_r;
   ats_pkg::result_type end_r;
   ats_pkg::result_type other_r;

   function automatic ats_pkg::result_type make_result(
      input ats_pkg::kind_type kind,
      input ats_pkg::pos_type  start,
      input ats_pkg::line_type line,
      input ats_pkg::pos_type  len,
      input ats_pkg::pos_type  base
   );
      ats_pkg::result_type r;
      ats_pkg::pos_type    col;
      col      = (start >= base) ? start - base : '0;
      r.kind   = kind;
      r.line   = ats_pkg::sat_line16(line);
      r.column = ats_pkg::sat_pos16(col);
      r.offset = ats_pkg::sat_pos24(start);
      r.length = ats_pkg::sat_pos16(len);
      r.last   = 1'b0;
      return r;
   endfunction

   // Character classes.
   always_comb begin
      is_letter  = char_code inside {[8'h61:8'h7A], [8'h41:8'h5A]};
      is_alnum   = is_letter || (char_code inside {[8'h30:8'h39]});
      is_space   = char_code inside {ats_pkg::CHAR_SPACE, ats_pkg::CHAR_TAB,
                                     ats_pkg::CHAR_NEWLINE, ats_pkg::CHAR_VTAB,
                                     ats_pkg::CHAR_FF, ats_pkg::CHAR_CR};
      is_blank   = char_code inside {ats_pkg::CHAR_SPACE, ats_pkg::CHAR_TAB};
      is_newline = (char_code == ats_pkg::CHAR_NEWLINE);
      is_punct   = 1'b1;
      punct_kind = ats_pkg::KIND_ERROR;
      case (char_code)
         ats_pkg::CHAR_LPAREN: punct_kind = ats_pkg::KIND_LPAREN;
         ats_pkg::CHAR_RPAREN: punct_kind = ats_pkg::KIND_RPAREN;
         ats_pkg::CHAR_BANG:   punct_kind = ats_pkg::KIND_NOT;
         ats_pkg::CHAR_AMP:    punct_kind = ats_pkg::KIND_AND;
         ats_pkg::CHAR_PIPE:   punct_kind = ats_pkg::KIND_OR;
         ats_pkg::CHAR_DASH:   punct_kind = ats_pkg::KIND_DASH;
         ats_pkg::CHAR_GT:     punct_kind = ats_pkg::KIND_GT;
         default:              is_punct   = 1'b0;
      endcase
   end

   // Decide whether the byte is scanned as a fresh token start and whether a
   // pending identifier closes on this beat.
   always_comb begin
      do_scan  = 1'b0;
      do_flush = 1'b0;
      case (mode_ff)
         ats_pkg::MODE_IDLE: begin
            do_scan = !op;
         end
         ats_pkg::MODE_IDENT: begin
            do_scan  = !op && !is_alnum;
            do_flush = op || !is_alnum;
         end
         ats_pkg::MODE_SKIP: begin
            do_scan = !op && is_space;
         end
         default: begin
            do_scan = !op;
         end
      endcase
   end

   // Next state.
   always_comb begin
      mode_in       = mode_ff;
      byte_in       = byte_ff;
      line_in       = line_ff;
      line_start_in = line_start_ff;
      tok_start_in  = tok_start_ff;
      tok_line_in   = tok_line_ff;
      if (fire) begin
         if (op) begin
            // The end marker returns everything to the reset state.
            mode_in       = ats_pkg::MODE_IDLE;
            byte_in       = '0;
            line_in       = '0;
            line_start_in = '0;
            tok_start_in  = '0;
            tok_line_in   = '0;
         end else begin
            byte_in = ats_pkg::pos_inc(byte_ff);
            if (do_scan) begin
               tok_start_in = byte_ff;
               tok_line_in  = line_ff;
               if (is_newline) begin
                  mode_in       = ats_pkg::MODE_IDLE;
                  line_in       = ats_pkg::line_inc(line_ff);
                  line_start_in = ats_pkg::pos_inc(byte_ff);
               end else if (is_blank || is_punct) begin
                  mode_in = ats_pkg::MODE_IDLE;
               end else if (is_letter) begin
                  mode_in = ats_pkg::MODE_IDENT;
               end else begin
                  mode_in = ats_pkg::MODE_SKIP;
               end
            end
         end
      end
   end

   // Results of this beat.
   always_comb begin
      flush_r = make_result(ats_pkg::KIND_VARIABLE, tok_start_ff, tok_line_ff,
                            byte_ff - tok_start_ff, line_start_ff);
      scan_r  = make_result(is_punct ? punct_kind : ats_pkg::KIND_ERROR,
                            byte_ff, line_ff, '0, line_start_ff);
      end_r   = make_result(ats_pkg::KIND_END, byte_ff, line_ff, '0, line_start_ff);

      scan_emit   = do_scan && (is_punct || !(is_letter || is_blank || is_newline));
      other_valid = op || scan_emit;
      other_r     = op ? end_r : scan_r;

      push.first       = do_flush ? flush_r : other_r;
      push.first.last  = !(do_flush && other_valid);
      push.second      = other_r;
      push.second.last = 1'b1;
      push.count       = fire ? (2'(do_flush) + 2'(other_valid)) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= ats_pkg::MODE_IDLE;
         byte_ff       <= '0;
         line_ff       <= '0;
         line_start_ff <= '0;
         tok_start_ff  <= '0;
         tok_line_ff   <= '0;
      end else begin
         mode_ff       <= mode_in;
         byte_ff       <= byte_in;
         line_ff       <= line_in;
         line_start_ff <= line_start_in;
         tok_start_ff  <= tok_start_in;
         tok_line_ff   <= tok_line_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ats_result_fifo.sv =====
// Small result queue: takes up to two results per cycle, delivers one per beat.
// Depends on ats_pkg.
`default_nettype none

module ats_result_fifo (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire ats_pkg::push_type push,
   output logic                room,
   output logic                out_valid,
   input  wire logic           out_stall,
   output ats_pkg::result_type out_data
);

   ats_pkg::result_type entries_ff [ats_pkg::FIFO_DEPTH];
   logic [ats_pkg::FIFO_PTR_W-1:0] head_ff, head_in;
   logic [ats_pkg::FIFO_PTR_W-1:0] tail_ff, tail_in;
   logic [ats_pkg::FIFO_PTR_W-1:0] tail_next;
   logic [ats_pkg::FIFO_CNT_W-1:0] count_ff, count_in;
   logic [ats_pkg::FIFO_CNT_W-1:0] after_pop;
   logic                           pop;

   always_comb begin
      out_valid = (count_ff != '0);
      out_data  = entries_ff[head_ff];
      pop       = out_valid && !out_stall;
      after_pop = count_ff - ats_pkg::FIFO_CNT_W'(pop);
      // Room for a full two-result beat after this cycle's pop.
      room      = after_pop <= ats_pkg::FIFO_CNT_W'(ats_pkg::FIFO_DEPTH - 2);
      tail_next = tail_ff + ats_pkg::FIFO_PTR_W'(1);
      tail_in   = tail_ff + ats_pkg::FIFO_PTR_W'(push.count);
      head_in   = head_ff + ats_pkg::FIFO_PTR_W'(pop);
      count_in  = after_pop + ats_pkg::FIFO_CNT_W'(push.count);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[tail_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= ats_pkg::FIFO_DEPTH)
      else $error("result queue count exceeds its depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      int'(after_pop) + int'(push.count) <= ats_pkg::FIFO_DEPTH)
      else $error("results pushed into a full queue");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      (!pop && push.count == 2'd0) |=> $stable(count_ff) && $stable(head_ff))
      else $error("result queue moved without a push or pop");

endmodule

`default_nettype wire
